[sv/mscs_pkg.sv]
// Shared types, constants and the start code classifier for the MPEG start code scanner.
package mscs_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned KIND_W   = 4;
	localparam int unsigned SIZE_W   = 12;
	localparam int unsigned RATE_W   = 4;
	localparam int unsigned PICK_W   = 3;
	localparam int unsigned RECENT_W = 16;
	localparam int unsigned COUNT_W  = 3;
	localparam int unsigned STORE_W  = 24;

	localparam logic [COUNT_W-1:0] SEQ_LAST = 3'd3;
	localparam logic [COUNT_W-1:0] PIC_LAST = 3'd1;

	localparam logic [BYTE_W-1:0] CODE_SEQ    = 8'hB3;
	localparam logic [BYTE_W-1:0] CODE_PIC    = 8'h00;
	localparam logic [BYTE_W-1:0] CODE_PACK   = 8'hBA;
	localparam logic [BYTE_W-1:0] CODE_SYSTEM = 8'hBB;
	localparam logic [BYTE_W-1:0] CODE_GOP    = 8'hB8;
	localparam logic [BYTE_W-1:0] SLICE_LO    = 8'h01;
	localparam logic [BYTE_W-1:0] SLICE_HI    = 8'hAF;
	localparam logic [BYTE_W-1:0] AUDIO_LO    = 8'hC0;
	localparam logic [BYTE_W-1:0] AUDIO_HI    = 8'hDF;
	localparam logic [BYTE_W-1:0] VIDEO_LO    = 8'hE0;
	localparam logic [BYTE_W-1:0] VIDEO_HI    = 8'hEF;
	localparam logic [BYTE_W-1:0] PREFIX_END  = 8'h01;
	localparam logic [RECENT_W-1:0] RECENT_ZERO = 16'h0000;
	localparam logic [RECENT_W-1:0] RECENT_IDLE = 16'hFFFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEQ    = 4'd0,
		KIND_PIC    = 4'd1,
		KIND_PACK   = 4'd2,
		KIND_SYSTEM = 4'd3,
		KIND_GOP    = 4'd4,
		KIND_SLICE  = 4'd5,
		KIND_AUDIO  = 4'd6,
		KIND_VIDEO  = 4'd7,
		KIND_OTHER  = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		MODE_SCAN = 2'd0,
		MODE_CODE = 2'd1,
		MODE_SEQ  = 2'd2,
		MODE_PIC  = 2'd3
	} mode_t;

	function automatic kind_t classify(input logic [BYTE_W-1:0] b);
		kind_t k;
		if (b == CODE_SEQ)                         k = KIND_SEQ;
		else if (b == CODE_PIC)                    k = KIND_PIC;
		else if (b == CODE_PACK)                   k = KIND_PACK;
		else if (b == CODE_SYSTEM)                 k = KIND_SYSTEM;
		else if (b == CODE_GOP)                    k = KIND_GOP;
		else if (b >= SLICE_LO && b <= SLICE_HI)   k = KIND_SLICE;
		else if (b >= AUDIO_LO && b <= AUDIO_HI)   k = KIND_AUDIO;
		else if (b >= VIDEO_LO && b <= VIDEO_HI)   k = KIND_VIDEO;
		else                                       k = KIND_OTHER;
		return k;
	endfunction

endpackage

[sv/mscs_byte_if.sv]
// Stream byte channel with valid/ready handshake.
interface mscs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

[sv/mscs_code_if.sv]
// Start code report channel with valid/ready handshake.
interface mscs_code_if;
	logic        valid;
	logic        ready;
	logic [3:0]  code_kind;
	logic [7:0]  code_value;
	logic [11:0] frame_width;
	logic [11:0] frame_height;
	logic [3:0]  rate_code;
	logic [2:0]  picture_kind;

	modport source (output valid, output code_kind, output code_value, output frame_width,
		output frame_height, output rate_code, output picture_kind, input ready);
	modport sink (input valid, input code_kind, input code_value, input frame_width,
		input frame_height, input rate_code, input picture_kind, output ready);
endinterface

[sv/mpeg_start_code_scanner.sv]
// MPEG start code scanner: finds 00 00 01 prefixes and reports the classified start codes.
//
// The stream channel takes one raw byte per transfer; the codes channel gives one
// report per start code found. Sequence headers are reported after their fourth header
// byte with frame size and frame-rate code; picture start codes after their second
// header byte with the coding type; every other code right after the code byte.
// Prefix bytes, header bytes and plain data bytes produce no report.
// A byte is taken into an input register and processed there against the scanner
// state; its report (if any) is written into the output register when the byte
// advances, which waits while an earlier report is still held. One byte is taken every
// cycle while the output register is free or being drained; the single output register
// sets that figure.
// When the receiver stalls with a report waiting, the byte in the input register is held
// and stream ready drops in that same cycle, combinationally from the codes ready.
// Reset clears both registers' valid flags and returns the scanner to prefix search with
// an empty byte window.
module mpeg_start_code_scanner (
	input logic clk,
	input logic arst_n,
	mscs_byte_if.sink stream,
	mscs_code_if.source codes
);
	import mscs_pkg::*;

	logic                v_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                adv;

	mode_t               mode_q, mode_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [STORE_W-1:0]  store_q, store_d;
	logic [RECENT_W-1:0] recent_q, recent_d;

	logic                res_valid;
	kind_t               res_kind;
	logic [BYTE_W-1:0]   res_value;
	logic [SIZE_W-1:0]   res_width, res_height;
	logic [RATE_W-1:0]   res_rate;
	logic [PICK_W-1:0]   res_pick;
	kind_t               code_class;

	logic                out_valid_q;
	kind_t               kind_q;
	logic [BYTE_W-1:0]   value_q;
	logic [SIZE_W-1:0]   width_q, height_q;
	logic [RATE_W-1:0]   rate_q;
	logic [PICK_W-1:0]   pick_q;

	assign adv          = v_s1 && (!out_valid_q || codes.ready);
	assign stream.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (stream.ready) begin
			v_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
		end
	end

	assign code_class = classify(byte_s1);

	always_comb begin
		mode_d     = mode_q;
		count_d    = count_q;
		store_d    = store_q;
		recent_d   = recent_q;
		res_valid  = 1'b0;
		res_kind   = code_class;
		res_value  = byte_s1;
		res_width  = '0;
		res_height = '0;
		res_rate   = '0;
		res_pick   = '0;
		unique case (mode_q)
			MODE_SCAN: begin
				if (recent_q == RECENT_ZERO && byte_s1 == PREFIX_END) begin
					mode_d   = MODE_CODE;
					count_d  = '0;
					store_d  = '0;
					recent_d = RECENT_IDLE;
				end else begin
					recent_d = {recent_q[BYTE_W-1:0], byte_s1};
				end
			end
			MODE_CODE: begin
				count_d = '0;
				store_d = '0;
				if (code_class == KIND_SEQ) begin
					mode_d = MODE_SEQ;
				end else if (code_class == KIND_PIC) begin
					mode_d = MODE_PIC;
				end else begin
					res_valid = 1'b1;
					mode_d    = MODE_SCAN;
					recent_d  = RECENT_IDLE;
				end
			end
			MODE_SEQ: begin
				if (count_q != SEQ_LAST) begin
					store_d = {store_q[STORE_W-BYTE_W-1:0], byte_s1};
					count_d = count_q + 1'b1;
				end else begin
					res_valid  = 1'b1;
					res_kind   = KIND_SEQ;
					res_value  = CODE_SEQ;
					res_width  = store_q[23:12];
					res_height = store_q[11:0];
					res_rate   = byte_s1[RATE_W-1:0];
					mode_d     = MODE_SCAN;
					count_d    = '0;
					store_d    = '0;
					recent_d   = RECENT_IDLE;
				end
			end
			MODE_PIC: begin
				if (count_q != PIC_LAST) begin
					store_d = {store_q[STORE_W-BYTE_W-1:0], byte_s1};
					count_d = count_q + 1'b1;
				end else begin
					res_valid = 1'b1;
					res_kind  = KIND_PIC;
					res_value = CODE_PIC;
					res_pick  = byte_s1[5:3];
					mode_d    = MODE_SCAN;
					count_d   = '0;
					store_d   = '0;
					recent_d  = RECENT_IDLE;
				end
			end
			default: begin
				mode_d = MODE_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SCAN;
			count_q  <= '0;
			store_q  <= '0;
			recent_q <= RECENT_IDLE;
		end else if (adv) begin
			mode_q   <= mode_d;
			count_q  <= count_d;
			store_q  <= store_d;
			recent_q <= recent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			kind_q   <= res_kind;
			value_q  <= res_value;
			width_q  <= res_width;
			height_q <= res_height;
			rate_q   <= res_rate;
			pick_q   <= res_pick;
		end
	end

	assign codes.valid        = out_valid_q;
	assign codes.code_kind    = kind_q;
	assign codes.code_value   = value_q;
	assign codes.frame_width  = width_q;
	assign codes.frame_height = height_q;
	assign codes.rate_code    = rate_q;
	assign codes.picture_kind = pick_q;

	// Outside prefix search the byte window must stay cleared.
	a_window_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_SCAN |-> recent_q == RECENT_IDLE)
		else $error("byte window not cleared while collecting");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_SEQ |-> count_q <= SEQ_LAST) and
		(mode_q == MODE_PIC |-> count_q <= PIC_LAST))
		else $error("header byte count out of range");

	a_size_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q != KIND_SEQ |->
		width_q == '0 && height_q == '0 && rate_q == '0)
		else $error("size fields set on a non-sequence report");

	a_seq_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_SEQ |-> value_q == CODE_SEQ && pick_q == '0)
		else $error("sequence report carries wrong code value");

	a_report_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv))
		else $error("report appeared without a processed byte");

endmodule
